FILE: hdl/aeo_pkg.sv
// ----------------------------------------------------------------------------
// aeo_pkg
// shared constants for the order-0 arithmetic encoder
// ----------------------------------------------------------------------------
package aeo_pkg;

  localparam int unsigned NumSymbolsDefault = 256;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [14:0] SUM_MAX = 15'h7fff;
  localparam logic [15:0] TOP_MASK = 16'h8000;
  localparam logic [15:0] SECOND_MASK = 16'h4000;
  localparam logic [15:0] LOW_KEEP = 16'h3fff;

  localparam int unsigned PadBits = 16;

endpackage

FILE: hdl/arithmetic_encoder_order0.sv
// ----------------------------------------------------------------------------
// arithmetic_encoder_order0
// 16-bit integer arithmetic encoder with a static order-0 model
// ----------------------------------------------------------------------------
// One transaction at a time. A load does a table write plus a read of the
// end-of-stream total. An encode does three table reads, 2 multiplies and
// two 31-by-15-bit divisions on one shared restoring divider, then the
// underflow steps and emitted bits (at most 17 steps); each emitted bit
// waits for m_axis_tready.
// A finish adds the flush bit and 16 pad bits. The cumulative totals table
// is a memory with registered reads; after reset a clearing pass over all
// NUM_SYMBOLS+2 entries runs before the first transaction is accepted.
module arithmetic_encoder_order0
  import aeo_pkg::*;
#(
  parameter int unsigned NUM_SYMBOLS = NumSymbolsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] symbol, [15:8] count
  input  logic [15:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] bit_value, [16:1] opposite_count, [23:17] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned Depth = NUM_SYMBOLS + 2;
  localparam int unsigned AW = $clog2(Depth);
  localparam logic [AW-1:0] EosIdx = AW'(NUM_SYMBOLS);
  localparam logic [AW-1:0] ScaleIdx = AW'(NUM_SYMBOLS + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_LD_RD  = 5'd2;
  localparam logic [4:0] S_LD_WT  = 5'd3;
  localparam logic [4:0] S_LD_WR  = 5'd4;
  localparam logic [4:0] S_RD_SC  = 5'd5;
  localparam logic [4:0] S_RD_LC  = 5'd6;
  localparam logic [4:0] S_RD_HC  = 5'd7;
  localparam logic [4:0] S_GOT    = 5'd8;
  localparam logic [4:0] S_MULH   = 5'd9;
  localparam logic [4:0] S_DIVH   = 5'd10;
  localparam logic [4:0] S_MULL   = 5'd11;
  localparam logic [4:0] S_DIVL   = 5'd12;
  localparam logic [4:0] S_NORM   = 5'd13;
  localparam logic [4:0] S_EMIT   = 5'd14;
  localparam logic [4:0] S_FLUSH  = 5'd15;
  localparam logic [4:0] S_PAD    = 5'd16;

  logic [4:0] state_q, state_d;

  logic [14:0] mem [Depth];
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [14:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [AW-1:0] clr_q, clr_d;
  logic [7:0]  sym_q, sym_d, cnt_q, cnt_d;
  logic [15:0] low_q, low_d, high_q, high_d, pend_q, pend_d;
  logic [14:0] sum_q, sum_d, scale_q, scale_d, lc_q, lc_d, hc_q, hc_d;
  logic [16:0] range_q, range_d;
  logic [30:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [15:0] nlo_q, nlo_d, nhi_q, nhi_d;
  logic [4:0]  guard_q, guard_d;
  logic [4:0]  pad_q, pad_d;
  logic        obit_q, obit_d;
  logic [15:0] ocnt_q, ocnt_d;
  logic        olast_q, olast_d;
  logic        ovalid_q, ovalid_d;
  logic        fin_q, fin_d;

  logic        in_fire, out_fire;
  logic [15:0] rem_sh;
  logic [16:0] pend_p1;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, ocnt_q, obit_q};
  assign m_axis_tlast  = olast_q;
  assign rem_sh  = {rem_q[14:0], quo_q[30]};
  assign pend_p1 = {1'b0, pend_q} + 17'd1;

  always_comb begin
    state_d = state_q; clr_d = clr_q; sym_d = sym_q; cnt_d = cnt_q;
    low_d = low_q; high_d = high_q; pend_d = pend_q; sum_d = sum_q;
    scale_d = scale_q; lc_d = lc_q; hc_d = hc_q; range_d = range_q;
    quo_d = quo_q; rem_d = rem_q; dcnt_d = dcnt_q;
    nlo_d = nlo_q; nhi_d = nhi_q; guard_d = guard_q; pad_d = pad_q;
    obit_d = obit_q; ocnt_d = ocnt_q; olast_d = olast_q; ovalid_d = ovalid_q;
    fin_d = fin_q;
    we = 1'b0; waddr = clr_q; wdata = '0; raddr = ScaleIdx;
    if (out_fire) ovalid_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == LastIdx) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          sym_d = s_axis_tdata[7:0];
          cnt_d = s_axis_tdata[15:8];
          case (s_axis_tuser)
            CMD_LOAD: begin
              if (32'(s_axis_tdata[7:0]) < NUM_SYMBOLS) state_d = S_LD_RD;
            end
            CMD_ENCODE: begin
              fin_d = 1'b0;
              if (32'(s_axis_tdata[7:0]) < NUM_SYMBOLS) state_d = S_RD_SC;
            end
            CMD_FINISH: begin
              fin_d = 1'b1;
              state_d = S_RD_SC;
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        // write the new cumulative entry, then read the eos entry
        logic [15:0] s;
        s = (sym_q == 8'd0 ? 16'd0 : {1'b0, sum_q}) + {8'd0, cnt_q};
        if (s > {1'b0, SUM_MAX}) s = {1'b0, SUM_MAX};
        sum_d = s[14:0];
        we = 1'b1; waddr = AW'({1'b0, sym_q} + 9'd1); wdata = s[14:0];
        state_d = S_LD_WT;
      end
      S_LD_WT: begin
        raddr = EosIdx;
        state_d = S_LD_WR;
      end
      S_LD_WR: begin
        logic [15:0] e;
        e = {1'b0, rdata_q} + 16'd1;
        if (e > {1'b0, SUM_MAX}) e = {1'b0, SUM_MAX};
        we = 1'b1; waddr = ScaleIdx; wdata = e[14:0];
        state_d = S_IDLE;
      end
      S_RD_SC: begin
        raddr = ScaleIdx;
        state_d = S_RD_LC;
      end
      S_RD_LC: begin
        scale_d = rdata_q;
        raddr = fin_q ? EosIdx : AW'(sym_q);
        state_d = S_RD_HC;
      end
      S_RD_HC: begin
        lc_d = rdata_q;
        raddr = fin_q ? ScaleIdx : AW'({1'b0, sym_q} + 9'd1);
        state_d = S_GOT;
      end
      S_GOT: begin
        hc_d = rdata_q;
        range_d = {1'b0, high_q - low_q} + 17'd1;
        if (scale_q == 15'd0) state_d = fin_q ? S_FLUSH : S_IDLE;
        else state_d = S_MULH;
      end
      S_MULH: begin
        state_d = S_DIVH;
        quo_d = 31'({14'd0, range_q} * {16'd0, hc_q}); rem_d = '0; dcnt_d = '0;
      end
      S_DIVH, S_DIVL: begin
        // one restoring division step per cycle
        logic [15:0] t;
        t = rem_sh - {1'b0, scale_q};
        if (rem_sh >= {1'b0, scale_q}) rem_d = t; else rem_d = rem_sh;
        quo_d = {quo_q[29:0], rem_sh >= {1'b0, scale_q}};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd30) begin
          if (state_q == S_DIVH) begin
            nhi_d = low_q + quo_d[15:0] - 16'd1;
            state_d = S_MULL;
          end else begin
            nlo_d = low_q + quo_d[15:0];
            guard_d = '0;
            state_d = S_NORM;
          end
        end
      end
      S_MULL: begin
        quo_d = 31'({14'd0, range_q} * {16'd0, lc_q}); rem_d = '0; dcnt_d = '0;
        state_d = S_DIVL;
      end
      S_NORM: begin
        if (!ovalid_q || out_fire) begin
          if (guard_q == 5'd17) begin
            low_d = nlo_q; high_d = nhi_q;
            state_d = fin_q ? S_FLUSH : S_IDLE;
          end else if (((nhi_q ^ nlo_q) & TOP_MASK) == 16'd0) begin
            obit_d = nhi_q[15]; ocnt_d = pend_q;
            olast_d = 1'b0; pend_d = '0;
            nlo_d = {nlo_q[14:0], 1'b0}; nhi_d = {nhi_q[14:0], 1'b1};
            guard_d = guard_q + 5'd1;
            state_d = S_EMIT;
          end else if (nlo_q[14] && !nhi_q[14]) begin
            if (pend_q != 16'hffff) pend_d = pend_q + 16'd1;
            nlo_d = {nlo_q[14:0] & LOW_KEEP[14:0], 1'b0};
            nhi_d = {nhi_q[14:0] | SECOND_MASK[14:0], 1'b1};
            guard_d = guard_q + 5'd1;
          end else begin
            low_d = nlo_q; high_d = nhi_q;
            state_d = fin_q ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_EMIT: begin
        // decide whether the bit just staged is the final one
        logic more;
        ovalid_d = 1'b1;
        more = fin_q || (guard_q != 5'd17 &&
               ((((nhi_q ^ nlo_q) & TOP_MASK) == 16'd0) || (nlo_q[14] && !nhi_q[14])));
        if (!more) begin
          olast_d = 1'b1;
          low_d = nlo_q; high_d = nhi_q;
          state_d = S_IDLE;
        end else state_d = S_NORM;
        // a later underflow that ends without a bit needs last on this one
        if (more && !fin_q) begin
          logic [15:0] l, h; logic [4:0] g; logic emit_ahead;
          l = nlo_q; h = nhi_q; g = guard_q; emit_ahead = 1'b0;
          for (int k = 0; k < 17; k++) begin
            if (g != 5'd17 && !emit_ahead) begin
              if (((h ^ l) & TOP_MASK) == 16'd0) emit_ahead = 1'b1;
              else if (l[14] && !h[14]) begin
                l = {l[14:0] & 15'h3fff, 1'b0}; h = {h[14:0] | 15'h4000, 1'b1};
                g = g + 5'd1;
              end else g = 5'd17;
            end
          end
          if (!emit_ahead) olast_d = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!ovalid_q || out_fire) begin
          ovalid_d = 1'b1; obit_d = low_q[14]; olast_d = 1'b0;
          ocnt_d = pend_p1[16] ? 16'hffff : pend_p1[15:0];
          pad_d = '0;
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        if (!ovalid_q || out_fire) begin
          ovalid_d = 1'b1; obit_d = 1'b0; ocnt_d = '0;
          olast_d = (pad_q == 5'(PadBits - 1));
          pad_d = pad_q + 5'd1;
          if (pad_q == 5'(PadBits - 1)) begin
            low_d = '0; high_d = 16'hffff; pend_d = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; low_q <= '0; high_q <= 16'hffff;
      pend_q <= '0; sum_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; low_q <= low_d; high_q <= high_d;
      pend_q <= pend_d; sum_q <= sum_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; cnt_q <= cnt_d; scale_q <= scale_d;
    lc_q <= lc_d; hc_q <= hc_d; range_q <= range_d;
    quo_q <= quo_d; rem_q <= rem_d; dcnt_q <= dcnt_d; nlo_q <= nlo_d;
    nhi_q <= nhi_d; guard_q <= guard_d; pad_q <= pad_d; obit_q <= obit_d;
    ocnt_q <= ocnt_d; olast_q <= olast_d; fin_q <= fin_d;
  end

endmodule

FILE: hdl/aeo_checker.sv
// ----------------------------------------------------------------------------
// aeo_checker
// port-level checks for the arithmetic encoder
// ----------------------------------------------------------------------------
module aeo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
    else $error("nonzero fill bits");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted mid-result");

endmodule

bind arithmetic_encoder_order0 aeo_checker u_aeo_checker (.*);

FILE: tb/tb_arithmetic_encoder_order0.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arithmetic_encoder_order0
// streams load, encode and finish transactions into the order-0 encoder and
// checks every emitted code bit against a behavioral copy of the coder
// ----------------------------------------------------------------------------
module tb_arithmetic_encoder_order0;
  import aeo_pkg::*;

  localparam int NSYM = NumSymbolsDefault;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] sym;
    logic [7:0] cnt;
  } item_t;

  typedef struct packed {
    logic        bit_v;
    logic [15:0] opp;
    logic        last;
  } code_bit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  arithmetic_encoder_order0 uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // coder state copy
  logic [15:0] iv_lo, iv_hi, pend;
  logic [14:0] cum_tab [NSYM+2];
  logic [14:0] run_sum;

  item_t     pending_items [$];
  code_bit_t code_bits_due [$];
  int        err_cnt = 0;
  bit        quiet = 1'b0;
  bit        hold_off = 1'b0;
  bit        all_sent = 1'b0;
  int        s_gap = 0, m_gap = 0, idle_cycles = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_cnt++;
  endtask

  task automatic push_bit(input logic b, input logic [15:0] c);
    code_bit_t r;
    r.bit_v = b;
    r.opp = c;
    r.last = 1'b0;
    code_bits_due.push_back(r);
  endtask

  task automatic narrow_interval(input int idx);
    longint scale, lc, hc, rng, lo, hi;
    int g;
    scale = cum_tab[NSYM+1];
    if (scale == 0) return;
    lc = cum_tab[idx];
    hc = cum_tab[idx+1];
    rng = longint'(16'(iv_hi - iv_lo)) + 1;
    lo = iv_lo;
    hi = (lo + (rng * hc) / scale - 1) & 16'hffff;
    lo = (lo + (rng * lc) / scale) & 16'hffff;
    for (g = 0; g < 17; g++) begin
      if (((hi ^ lo) & 16'h8000) == 0) begin
        push_bit(hi[15], pend);
        pend = '0;
      end else if ((lo & 16'h4000) != 0 && (hi & 16'h4000) == 0) begin
        if (pend != 16'hffff) pend++;
        lo &= 16'h3fff;
        hi |= 16'h4000;
      end else begin
        break;
      end
      lo = (lo << 1) & 16'hffff;
      hi = ((hi << 1) | 1) & 16'hffff;
    end
    iv_lo = lo[15:0];
    iv_hi = hi[15:0];
  endtask

  task automatic predict_code(input item_t it);
    int n0;
    int s, e;
    n0 = code_bits_due.size();
    case (it.cmd)
      CMD_LOAD: begin
        s = (it.sym == 0 ? 0 : int'(run_sum)) + it.cnt;
        if (s > 32767) s = 32767;
        run_sum = s[14:0];
        cum_tab[it.sym+1] = s[14:0];
        e = int'(cum_tab[NSYM]) + 1;
        if (e > 32767) e = 32767;
        cum_tab[NSYM+1] = e[14:0];
      end
      CMD_ENCODE: narrow_interval(it.sym);
      CMD_FINISH: begin
        narrow_interval(NSYM);
        push_bit(iv_lo[14], (pend == 16'hffff) ? 16'hffff : pend + 16'd1);
        repeat (PadBits) push_bit(1'b0, 16'd0);
        iv_lo = '0;
        iv_hi = 16'hffff;
        pend = '0;
      end
      default: ;
    endcase
    if (code_bits_due.size() > n0) code_bits_due[$].last = 1'b1;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_code({s_axis_tuser, s_axis_tdata[7:0],
                                                        s_axis_tdata[15:8]});
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (s_gap > 0) begin
          s_gap <= s_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          s_gap <= $urandom_range(1, 5);
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_off) begin
          item_t it;
          it = pending_items.pop_front();
          s_axis_tuser <= it.cmd;
          s_axis_tdata <= {it.cnt, it.sym};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        code_bit_t w;
        if (code_bits_due.size() == 0) begin
          report("unexpected code bit", m_axis_tdata, 0);
        end else begin
          w = code_bits_due.pop_front();
          if (m_axis_tdata[0] !== w.bit_v) report("bit_value", m_axis_tdata[0], w.bit_v);
          if (m_axis_tdata[16:1] !== w.opp) report("opposite_count", m_axis_tdata[16:1], w.opp);
          if (m_axis_tdata[23:17] !== 7'd0) report("pad field", m_axis_tdata[23:17], 0);
          if (m_axis_tlast !== w.last) report("tlast", m_axis_tlast, w.last);
        end
      end
      if (m_gap > 0) begin
        m_gap <= m_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_gap <= $urandom_range(1, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic item_t mk(input logic [1:0] c, input int s, input int n);
    item_t it;
    it.cmd = c;
    it.sym = s[7:0];
    it.cnt = n[7:0];
    return it;
  endfunction

  // sparse table: every 36th symbol plus the top one, others keep old entries
  task automatic add_table(input int mode);
    int k, c, s;
    for (k = 0; k < 9; k++) begin
      s = (k == 8) ? NSYM - 1 : k * 36;
      case (mode)
        0: c = $urandom_range(0, 6);
        1: c = 255;
        default: c = (k % 3 == 0) ? 0 : $urandom_range(1, 255);
      endcase
      pending_items.push_back(mk(CMD_LOAD, s, c));
    end
  endtask

  task automatic add_stream(input int len, input bit noisy);
    int k;
    for (k = 0; k < len; k++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        pending_items.push_back(mk(CMD_UNDEF, $urandom, $urandom));
      else if (noisy && $urandom_range(0, 9) == 0)
        pending_items.push_back(mk(CMD_LOAD, $urandom, $urandom));
      else if ($urandom_range(0, 1) == 0)
        pending_items.push_back(mk(CMD_ENCODE, 36 * $urandom_range(0, 7), $urandom));
      else
        pending_items.push_back(mk(CMD_ENCODE, $urandom, $urandom));
    end
    pending_items.push_back(mk(CMD_FINISH, $urandom, $urandom));
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || code_bits_due.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int k;
    iv_lo = '0; iv_hi = 16'hffff; pend = '0; run_sum = '0;
    for (k = 0; k < NSYM + 2; k++) cum_tab[k] = '0;
    // directed: empty model encode and finish, undefined command
    pending_items.push_back(mk(CMD_ENCODE, 0, 0));
    pending_items.push_back(mk(CMD_UNDEF, 255, 255));
    pending_items.push_back(mk(CMD_FINISH, 0, 0));
    // partial table, extreme byte values
    pending_items.push_back(mk(CMD_LOAD, 0, 255));
    pending_items.push_back(mk(CMD_LOAD, 1, 0));
    pending_items.push_back(mk(CMD_LOAD, 255, 1));
    pending_items.push_back(mk(CMD_LOAD, 3, 128));
    pending_items.push_back(mk(CMD_LOAD, 3, 127));
    pending_items.push_back(mk(CMD_ENCODE, 0, 255));
    pending_items.push_back(mk(CMD_ENCODE, 255, 0));
    pending_items.push_back(mk(CMD_ENCODE, 1, 0));
    pending_items.push_back(mk(CMD_ENCODE, 3, 0));
    pending_items.push_back(mk(CMD_ENCODE, 3, 0));
    pending_items.push_back(mk(CMD_FINISH, 255, 255));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();
    // large counts
    add_table(1);
    add_stream(8, 1'b0);
    wait_drained();
    hold_off = 1'b1;
    repeat (100) @(posedge clk_i);
    hold_off = 1'b0;
    // skewed table with zero counts, noisy stream
    add_table(2);
    add_stream(25, 1'b1);
    // small counts push the underflow path
    add_table(0);
    add_stream(20, 1'b1);
    wait_drained();
    quiet = 1'b1;
    add_stream(12, 1'b0);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && code_bits_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
